// ===== sv/wma_pkg.sv =====
`default_nettype none

package wma_pkg;

    localparam int MAX_WINDOW    = 32;
    localparam int SAMPLE_BITS   = 32;
    localparam int PTR_BITS      = $clog2(MAX_WINDOW);
    localparam int FILL_BITS     = PTR_BITS + 1;
    localparam int WEIGHT_BITS   = 19;
    localparam int MUL_A_BITS    = 32;
    localparam int MUL_B_BITS    = 25;
    localparam int MUL_P_BITS    = MUL_A_BITS + MUL_B_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 25;

    localparam logic [CFG_IDX_BITS-1:0] CFG_EMA_MODE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHAPE      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INV_SUM    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EMA_GAIN   = 3'd4;

    localparam logic [1:0] WS_FLAT   = 2'd0;
    localparam logic [1:0] WS_SQRT   = 2'd1;
    localparam logic [1:0] WS_LINEAR = 2'd2;
    localparam logic [1:0] WS_SQUARE = 2'd3;

    typedef struct packed {
        logic                   en;
        logic [PTR_BITS-1:0]    addr;
        logic [SAMPLE_BITS-1:0] data;
    } t_hist_wr;

    // floor(256 * sqrt(k))
    function automatic logic [10:0] sqrt_rom(input logic [5:0] k);
        logic [10:0] v;
        case (k)
            6'd1:    v = 11'd256;
            6'd2:    v = 11'd362;
            6'd3:    v = 11'd443;
            6'd4:    v = 11'd512;
            6'd5:    v = 11'd572;
            6'd6:    v = 11'd627;
            6'd7:    v = 11'd677;
            6'd8:    v = 11'd724;
            6'd9:    v = 11'd768;
            6'd10:   v = 11'd809;
            6'd11:   v = 11'd849;
            6'd12:   v = 11'd886;
            6'd13:   v = 11'd923;
            6'd14:   v = 11'd957;
            6'd15:   v = 11'd991;
            6'd16:   v = 11'd1024;
            6'd17:   v = 11'd1055;
            6'd18:   v = 11'd1086;
            6'd19:   v = 11'd1115;
            6'd20:   v = 11'd1144;
            6'd21:   v = 11'd1173;
            6'd22:   v = 11'd1200;
            6'd23:   v = 11'd1227;
            6'd24:   v = 11'd1254;
            6'd25:   v = 11'd1280;
            6'd26:   v = 11'd1305;
            6'd27:   v = 11'd1330;
            6'd28:   v = 11'd1354;
            6'd29:   v = 11'd1378;
            6'd30:   v = 11'd1402;
            6'd31:   v = 11'd1425;
            6'd32:   v = 11'd1448;
            default: v = 11'd0;
        endcase
        return v;
    endfunction

    // tap weight, 8 fraction bits
    function automatic logic [WEIGHT_BITS-1:0] tap_weight(input logic [1:0] shape,
                                                          input logic [5:0] k);
        logic [11:0]            kk;
        logic [WEIGHT_BITS-1:0] w;
        kk = {6'd0, k} * {6'd0, k};
        case (shape)
            WS_FLAT:   w = 19'd256;
            WS_SQRT:   w = {8'd0, sqrt_rom(k)};
            WS_LINEAR: w = {5'd0, k, 8'd0};
            WS_SQUARE: w = {kk[10:0], 8'd0};
            default:   w = 19'd256;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wma_hist.sv =====
`default_nettype none

module wma_hist import wma_pkg::*; (
    input  logic                   i_clk,
    input  t_hist_wr               i_wr,
    input  logic [PTR_BITS-1:0]    i_raddr,
    output logic [SAMPLE_BITS-1:0] o_rdata
);

    logic [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/wma_mul.sv =====
`default_nettype none

module wma_mul import wma_pkg::*; (
    input  logic                  i_clk,
    input  logic [MUL_A_BITS-1:0] i_a,
    input  logic [MUL_B_BITS-1:0] i_b,
    output logic [MUL_P_BITS-1:0] o_p
);

    logic [MUL_P_BITS-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {{MUL_B_BITS{1'b0}}, i_a} * {{MUL_A_BITS{1'b0}}, i_b};
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== sv/weighted_or_exponential_moving_average.sv =====
`default_nettype none

// channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------
// input    | i_in_valid   | o_in_ready   | i_sample, i_series_start
// output   | o_out_valid  | i_out_ready  | o_average
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Window mode: one multiply per tap on the shared 32x25 multiplier, then two
// partial products for normalization; a beat that does not fill the window
// produces no average and returns straight to idle.
// EMA mode: the first sample of a series is output as is, with no update.
// Reset is synchronous; history needs no clearing pass.
// Input is taken only in idle; a stalled output holds the sequencer before
// it returns to idle.

module weighted_or_exponential_moving_average import wma_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    input  logic                     i_series_start,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [SAMPLE_BITS-1:0]   o_average,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int ACC_BITS = 56;
    localparam int MAG_BITS = ACC_BITS - 1;
    localparam int SUM_BITS = 50;
    localparam int UPD_BITS = SAMPLE_BITS + 3;

    typedef enum logic [3:0] {
        S_IDLE, S_TAPS, S_ABS, S_NLO, S_NHI, S_NFIN, S_WSAT,
        S_EDIFF, S_EMUL, S_EMAG, S_EUPD, S_OUT
    } t_state;

    t_state r_state;

    logic                     r_ema_mode;
    logic [5:0]               r_window_len;
    logic [1:0]               r_weight_shape;
    logic [24:0]              r_inv;
    logic [16:0]              r_gain;

    logic [PTR_BITS-1:0]      r_wp;
    logic [FILL_BITS-1:0]     r_fill;
    logic [SAMPLE_BITS-1:0]   r_ema;
    logic [SAMPLE_BITS-1:0]   r_smp;
    logic [FILL_BITS-1:0]     r_cnt;
    logic                     r_v1;
    logic [5:0]               r_k1;
    logic                     r_v2;
    logic                     r_sgn2;
    logic signed [ACC_BITS-1:0] r_acc;
    logic                     r_neg;
    logic [MAG_BITS-1:0]      r_mag;
    logic [25:0]              r_t;
    logic [SUM_BITS-1:0]      r_sum;
    logic                     r_dneg;
    logic [31:0]              r_dmag;
    logic [33:0]              r_emag;
    logic [SAMPLE_BITS-1:0]   r_res;
    logic                     r_o_valid;
    logic [SAMPLE_BITS-1:0]   r_o_avg;

    logic                     w_in_acc;
    logic [5:0]               w_len;
    logic [PTR_BITS-1:0]      w_wp_base;
    logic [FILL_BITS-1:0]     w_fill_base;
    logic [PTR_BITS-1:0]      n_wp;
    logic [FILL_BITS-1:0]     n_fill;
    logic                     w_issue;
    logic [PTR_BITS-1:0]      w_raddr;
    logic [SAMPLE_BITS-1:0]   w_rdata;
    logic [31:0]              w_tap_abs;
    logic [WEIGHT_BITS-1:0]   w_weight;
    logic [MUL_A_BITS-1:0]    w_mul_a;
    logic [MUL_B_BITS-1:0]    w_mul_b;
    logic [MUL_P_BITS-1:0]    w_p;
    logic [ACC_BITS-1:0]      w_tap_prod;
    logic [ACC_BITS-1:0]      w_acc_neg;
    logic [57:0]              w_lo_rnd;
    logic [32:0]              w_diff;
    logic [32:0]              w_diff_neg;
    logic [50:0]              w_emag_rnd;
    logic signed [UPD_BITS-1:0] w_ema_ext;
    logic signed [UPD_BITS-1:0] w_emag_ext;
    logic signed [UPD_BITS-1:0] w_upd;
    logic signed [UPD_BITS-1:0] w_smax;
    logic signed [UPD_BITS-1:0] w_smin;
    t_hist_wr                 w_hwr;

    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_o_valid;
    assign o_average   = r_o_avg;
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        if (r_window_len == 6'd0) begin
            w_len = 6'd1;
        end else if (r_window_len > 6'(MAX_WINDOW)) begin
            w_len = 6'(MAX_WINDOW);
        end else begin
            w_len = r_window_len;
        end
    end

    assign w_wp_base   = i_series_start ? '0 : r_wp;
    assign w_fill_base = i_series_start ? '0 : r_fill;
    assign n_wp        = w_wp_base + 1'b1;
    assign n_fill      = (w_fill_base == FILL_BITS'(MAX_WINDOW)) ?
                         w_fill_base : w_fill_base + 1'b1;

    assign w_hwr.en   = w_in_acc;
    assign w_hwr.addr = w_wp_base;
    assign w_hwr.data = i_sample;

    assign w_issue = (r_state == S_TAPS) && (r_cnt < w_len);
    assign w_raddr = r_wp - 1'b1 - r_cnt[PTR_BITS-1:0];

    wma_hist u_hist (
        .i_clk   (i_clk),
        .i_wr    (w_hwr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_tap_abs = w_rdata[SAMPLE_BITS-1] ? (~w_rdata + 1'b1) : w_rdata;
    assign w_weight  = tap_weight(r_weight_shape, r_k1);

    always_comb begin
        case (r_state)
            S_NLO: begin
                w_mul_a = r_mag[31:0];
                w_mul_b = r_inv;
            end
            S_NHI: begin
                w_mul_a = {9'd0, r_mag[MAG_BITS-1:32]};
                w_mul_b = r_inv;
            end
            S_EMUL: begin
                w_mul_a = r_dmag;
                w_mul_b = {8'd0, r_gain};
            end
            default: begin
                w_mul_a = w_tap_abs;
                w_mul_b = {6'd0, w_weight};
            end
        endcase
    end

    wma_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    assign w_tap_prod = {1'b0, w_p[MAG_BITS-1:0]};
    assign w_acc_neg  = ~r_acc + 1'b1;
    assign w_lo_rnd   = {1'b0, w_p} + 58'h0_0000_8000_0000;
    assign w_diff     = {r_smp[SAMPLE_BITS-1], r_smp} - {r_ema[SAMPLE_BITS-1], r_ema};
    assign w_diff_neg = ~w_diff + 1'b1;
    assign w_emag_rnd = {1'b0, w_p[49:0]} + 51'd32768;
    assign w_ema_ext  = UPD_BITS'($signed(r_ema));
    assign w_emag_ext = $signed({1'b0, r_emag});
    assign w_upd      = r_dneg ? (w_ema_ext - w_emag_ext) : (w_ema_ext + w_emag_ext);
    assign w_smax     = UPD_BITS'($signed(SMAX));
    assign w_smin     = UPD_BITS'($signed(SMIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ema_mode     <= 1'b0;
            r_window_len   <= 6'd1;
            r_weight_shape <= WS_FLAT;
            r_inv          <= 25'd16777216;
            r_gain         <= 17'd65536;
            r_wp           <= '0;
            r_fill         <= '0;
            r_ema          <= '0;
            r_cnt          <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_EMA_MODE:   r_ema_mode     <= i_cfg_data[0];
                    CFG_WINDOW_LEN: r_window_len   <= i_cfg_data[5:0];
                    CFG_SHAPE:      r_weight_shape <= i_cfg_data[1:0];
                    CFG_INV_SUM:    r_inv          <= i_cfg_data[24:0];
                    CFG_EMA_GAIN:   r_gain         <= i_cfg_data[16:0];
                    default: ;
                endcase
            end

            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            // tap pipeline: read, multiply, accumulate
            r_v1   <= w_issue;
            r_k1   <= w_len - r_cnt;
            r_v2   <= r_v1;
            r_sgn2 <= w_rdata[SAMPLE_BITS-1];
            if (w_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_v2) begin
                r_acc <= r_sgn2 ? (r_acc - $signed(w_tap_prod))
                                : (r_acc + $signed(w_tap_prod));
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_wp  <= n_wp;
                        r_fill <= n_fill;
                        r_smp <= i_sample;
                        r_acc <= '0;
                        r_cnt <= '0;
                        if (r_ema_mode) begin
                            if (w_fill_base == '0) begin
                                r_ema   <= i_sample;
                                r_res   <= i_sample;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_EDIFF;
                            end
                        end else if (n_fill >= w_len) begin
                            r_state <= S_TAPS;
                        end
                    end
                end
                S_TAPS: begin
                    if ((r_cnt == w_len) && !r_v1 && !r_v2) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_acc[ACC_BITS-1];
                    r_mag   <= r_acc[ACC_BITS-1] ? w_acc_neg[MAG_BITS-1:0]
                                                 : r_acc[MAG_BITS-1:0];
                    r_state <= S_NLO;
                end
                S_NLO: begin
                    r_state <= S_NHI;
                end
                S_NHI: begin
                    r_t     <= w_lo_rnd[57:32];
                    r_state <= S_NFIN;
                end
                S_NFIN: begin
                    r_sum   <= {24'd0, r_t} + w_p[SUM_BITS-1:0];
                    r_state <= S_WSAT;
                end
                S_WSAT: begin
                    if (r_neg) begin
                        r_res <= (r_sum > SUM_BITS'(SMIN)) ? SMIN
                                                           : (~r_sum[31:0] + 1'b1);
                    end else begin
                        r_res <= (r_sum > SUM_BITS'(SMAX)) ? SMAX : r_sum[31:0];
                    end
                    r_state <= S_OUT;
                end
                S_EDIFF: begin
                    r_dneg  <= w_diff[32];
                    r_dmag  <= w_diff[32] ? w_diff_neg[31:0] : w_diff[31:0];
                    r_state <= S_EMUL;
                end
                S_EMUL: begin
                    r_state <= S_EMAG;
                end
                S_EMAG: begin
                    r_emag  <= w_emag_rnd[49:16];
                    r_state <= S_EUPD;
                end
                S_EUPD: begin
                    if (w_upd > w_smax) begin
                        r_ema <= SMAX;
                        r_res <= SMAX;
                    end else if (w_upd < w_smin) begin
                        r_ema <= SMIN;
                        r_res <= SMIN;
                    end else begin
                        r_ema <= w_upd[SAMPLE_BITS-1:0];
                        r_res <= w_upd[SAMPLE_BITS-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_avg   <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(MAX_WINDOW))
        else $error("fill count above window depth");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v1 && !r_v2))
        else $error("tap pipeline busy in idle");

    a_tap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAPS) |-> (r_cnt <= w_len))
        else $error("tap count past window length");

    a_ema_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_ema_mode) |=> (r_state != S_IDLE))
        else $error("ema beat produced no result");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_weighted_or_exponential_moving_average.sv =====
`timescale 1ns / 100ps

module tb_weighted_or_exponential_moving_average;
    import wma_pkg::*;

    localparam int SETTLE_CYCLES = 50;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_BEATS  = 880;
    localparam int DIR_ROWS      = 33;
    localparam bit ROW_CFG       = 1'b1;
    localparam bit ROW_BEAT      = 1'b0;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [SAMPLE_BITS-1:0]   i_sample;
    logic                     i_series_start;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [SAMPLE_BITS-1:0]   o_average;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    weighted_or_exponential_moving_average u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_series_start (i_series_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_average      (o_average),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // predictor state
    logic                          cfg_mode;
    logic [5:0]                    cfg_len;
    logic [1:0]                    cfg_shape;
    logic [24:0]                   cfg_inv;
    logic [16:0]                   cfg_gain;
    logic signed [SAMPLE_BITS-1:0] hist [MAX_WINDOW];
    logic [PTR_BITS-1:0]           wr_ptr;
    logic [FILL_BITS-1:0]          fill;
    logic signed [SAMPLE_BITS-1:0] ema_now;

    logic [SAMPLE_BITS-1:0] pending_averages [$];
    logic [SAMPLE_BITS-1:0] avg_want;
    int                     errors;
    bit                     in_gaps;
    bit                     out_gaps;

    typedef struct packed {
        bit                      is_cfg;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [SAMPLE_BITS-1:0]  val;
        logic                    start;
        bit                      typed;
        logic [SAMPLE_BITS-1:0]  avg;
    } t_dir_row;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_CFG,  CFG_EMA_MODE,   32'd1,         1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678},
        '{ROW_BEAT, '0,             32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h8000_0000, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_EMA_GAIN,   32'd0,         1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h0005_0000, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_EMA_GAIN,   32'h0001_FFFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{ROW_BEAT, '0,             32'h4000_0000, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_EMA_MODE,   32'd0,         1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
        '{ROW_BEAT, '0,             32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{ROW_BEAT, '0,             32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
        '{ROW_BEAT, '0,             32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
        '{ROW_CFG,  CFG_WINDOW_LEN, 32'd0,         1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h0000_0001, 1'b0, 1'b1, 32'h0000_0001},
        '{ROW_CFG,  CFG_WINDOW_LEN, 32'd3,         1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_SHAPE,      32'(WS_LINEAR), 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_INV_SUM,    32'd2796203,   1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h0003_0000, 1'b1, 1'b0, '0},
        '{ROW_BEAT, '0,             32'hFFFF_0000, 1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_SHAPE,      32'(WS_SQRT),  1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h8000_0000, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_SHAPE,      32'(WS_SQUARE), 1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h0001_8000, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_INV_SUM,    32'h01FF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_INV_SUM,    32'd0,         1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h1234_0000, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_EMA_MODE,   32'd1,         1'b0, 1'b0, '0},
        '{ROW_BEAT, '0,             32'h0002_0000, 1'b0, 1'b0, '0}
    };

    function automatic logic [SAMPLE_BITS-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // tap weight with 8 fraction bits
    function automatic longint weight_at(input logic [1:0] shape, input int k);
        longint root;
        longint trial;
        int     b;
        case (shape)
            WS_FLAT:   return 256;
            WS_SQRT: begin
                root = 0;
                for (b = 11; b >= 0; b--) begin
                    trial = root | (longint'(1) << b);
                    if (trial * trial <= (longint'(k) << 16)) begin
                        root = trial;
                    end
                end
                return root;
            end
            WS_LINEAR: return longint'(k) << 8;
            default:   return (longint'(k) * k) << 8;
        endcase
    endfunction

    function automatic int eff_len(input logic [5:0] l);
        if (l == 0) begin
            return 1;
        end
        if (l > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(l);
    endfunction

    // Q1.24 reciprocal of the real weight sum
    function automatic logic [24:0] inv_for(input logic [5:0] l, input logic [1:0] shape);
        longint sum;
        int     k;
        sum = 0;
        for (k = 1; k <= eff_len(l); k++) begin
            sum = sum + weight_at(shape, k);
        end
        return 25'(((longint'(1) << 32) + sum / 2) / sum);
    endfunction

    task automatic step_average(input logic [SAMPLE_BITS-1:0] smp, input logic start,
                                output bit has_avg, output logic [SAMPLE_BITS-1:0] avg);
        logic                first;
        int                  len;
        int                  i;
        int                  j;
        logic [PTR_BITS-1:0] idx;
        longint              diff;
        longint              acc;
        bit                  neg;
        longint unsigned     mag;
        logic [127:0]        prod;
        has_avg = 1'b0;
        avg     = '0;
        if (start) begin
            for (i = 0; i < MAX_WINDOW; i++) begin
                hist[i] = '0;
            end
            wr_ptr = '0;
            fill   = '0;
        end
        first        = (fill == 0);
        hist[wr_ptr] = smp;
        wr_ptr       = wr_ptr + 1'b1;
        if (fill < MAX_WINDOW) begin
            fill = fill + 1'b1;
        end
        if (cfg_mode) begin
            if (first) begin
                ema_now = smp;
            end else begin
                diff    = longint'($signed(smp)) - longint'(ema_now);
                mag     = ((diff < 0 ? -diff : diff) * cfg_gain + 64'd32768) >> 16;
                ema_now = clamp32(diff < 0 ? longint'(ema_now) - longint'(mag)
                                           : longint'(ema_now) + longint'(mag));
            end
            has_avg = 1'b1;
            avg     = ema_now;
        end else begin
            len = eff_len(cfg_len);
            if (fill >= len) begin
                acc = 0;
                for (j = 0; j < len; j++) begin
                    idx = PTR_BITS'(wr_ptr - 1 - j);
                    acc = acc + longint'(hist[idx]) * weight_at(cfg_shape, len - j);
                end
                neg  = (acc < 0);
                mag  = neg ? -acc : acc;
                prod = {64'd0, mag} * {103'd0, cfg_inv};
                prod = prod + (128'd1 << 31);
                mag  = prod[95:32];
                has_avg = 1'b1;
                avg     = clamp32(neg ? -longint'(mag) : longint'(mag));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_EMA_MODE:   cfg_mode  = data[0];
            CFG_WINDOW_LEN: cfg_len   = data[5:0];
            CFG_SHAPE:      cfg_shape = data[1:0];
            CFG_INV_SUM:    cfg_inv   = data[24:0];
            CFG_EMA_GAIN:   cfg_gain  = data[16:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [SAMPLE_BITS-1:0] smp, input logic start,
                             input bit typed, input logic [SAMPLE_BITS-1:0] typed_avg,
                             input bit hold_off);
        int                     gap;
        bit                     has_avg;
        logic [SAMPLE_BITS-1:0] avg;
        gap = in_gaps ? $urandom_range(0, 15) : 0;
        if (hold_off) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (pending_averages.size() != 0) begin
                @(posedge i_clk);
            end
        end else if (gap != 0) begin
            i_in_valid <= 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        i_in_valid     <= 1'b1;
        i_sample       <= smp;
        i_series_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        step_average(smp, start, has_avg, avg);
        if (has_avg) begin
            pending_averages.push_back(typed ? typed_avg : avg);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver with random stalls
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        forever begin
            stall = out_gaps ? $urandom_range(0, 15) : 0;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_averages.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected average beat: %h", o_average);
                end
            end else begin
                avg_want = pending_averages.pop_front();
                if (o_average !== avg_want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("average mismatch: expected %h, got %h", avg_want, o_average);
                    end
                end
            end
        end
    end

    initial begin
        logic                   mode;
        logic [5:0]             len;
        logic [1:0]             shape;
        logic [24:0]            inv;
        logic [16:0]            gain;
        logic [SAMPLE_BITS-1:0] smp;
        logic                   start;
        longint                 walk;
        int                     sent;
        int                     n;
        int                     k;
        int                     pick;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_sample       <= '0;
        i_series_start <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_EMA_MODE;
        i_cfg_data     <= '0;
        cfg_mode  = 1'b0;
        cfg_len   = 6'd1;
        cfg_shape = WS_FLAT;
        cfg_inv   = 25'h100_0000;
        cfg_gain  = 17'h1_0000;
        foreach (hist[i]) begin
            hist[i] = '0;
        end
        wr_ptr   = '0;
        fill     = '0;
        ema_now  = '0;
        errors   = 0;
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        walk     = 64'sd100 << 16;
        sent     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].is_cfg) begin
                write_reg(dir_rows[k].idx, dir_rows[k].val[CFG_DATA_BITS-1:0]);
            end else begin
                send_beat(dir_rows[k].val, dir_rows[k].start, dir_rows[k].typed,
                          dir_rows[k].avg, 1'b0);
            end
        end

        while (sent < RANDOM_BEATS) begin
            mode = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                len = 6'($urandom_range(1, 8));
            end else if (pick < 16) begin
                len = 6'($urandom_range(9, 31));
            end else if (pick == 16) begin
                len = 6'd32;
            end else if (pick == 17) begin
                len = 6'd0;
            end else begin
                len = 6'($urandom_range(33, 63));
            end
            shape = 2'($urandom_range(0, 3));
            pick  = $urandom_range(0, 19);
            if (pick < 17) begin
                inv = inv_for(len, shape);
            end else if (pick == 17) begin
                inv = '0;
            end else if (pick == 18) begin
                inv = '1;
            end else begin
                inv = 25'($urandom_range(0, 33554431));
            end
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                gain = 17'($urandom_range(0, 65536));
            end else if (pick < 16) begin
                gain = 17'h1_0000;
            end else if (pick == 16) begin
                gain = '0;
            end else if (pick == 17) begin
                gain = 17'($urandom_range(65537, 131071));
            end else begin
                gain = 17'($urandom_range(1, 4096));
            end
            write_reg(CFG_EMA_MODE, 25'(mode));
            write_reg(CFG_WINDOW_LEN, 25'(len));
            write_reg(CFG_SHAPE, 25'(shape));
            write_reg(CFG_INV_SUM, inv);
            write_reg(CFG_EMA_GAIN, 25'(gain));
            in_gaps  = ($urandom_range(0, 3) != 0);
            out_gaps = ($urandom_range(0, 3) != 0);
            n = (mode ? 0 : eff_len(len)) + $urandom_range(15, 45);
            for (k = 0; k < n; k++) begin
                if (k == 0) begin
                    start = 1'($urandom_range(0, 1));
                end else begin
                    start = ($urandom_range(0, mode ? 15 : 63) == 0);
                end
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    walk = walk + $urandom_range(0, 1048576) - 524288;
                    smp  = walk[31:0];
                end else if (pick < 8) begin
                    smp = $urandom();
                end else if (pick == 8) begin
                    smp = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end else begin
                    smp = 32'($urandom_range(0, 8)) - 32'd4;
                end
                send_beat(smp, start, 1'b0, '0, $urandom_range(0, 39) == 0);
                sent++;
            end
        end

        i_in_valid <= 1'b0;
        while (pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/wma_pkg.sv
sv/wma_hist.sv
sv/wma_mul.sv
sv/weighted_or_exponential_moving_average.sv
bench/tb_weighted_or_exponential_moving_average.sv
